[rtl/vrp_pkg.sv]
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared constants, command codes and address helpers for the video RAM
// access port with address remapping.
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

  // Depth of the video memory in 16-bit words. It must be a power of two
  // between 1024 and 65536, so that reducing an address to the depth is a mask.
  localparam int MEM_WORDS = 32768;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  // Field widths.
  localparam int OP_W   = 4;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;

  // Command codes carried by the opcode field.
  localparam logic [OP_W-1:0] OP_MODE_WR    = 4'd0;
  localparam logic [OP_W-1:0] OP_ADDR_LO    = 4'd1;
  localparam logic [OP_W-1:0] OP_ADDR_HI    = 4'd2;
  localparam logic [OP_W-1:0] OP_DATA_LO_WR = 4'd3;
  localparam logic [OP_W-1:0] OP_DATA_HI_WR = 4'd4;
  localparam logic [OP_W-1:0] OP_DATA_LO_RD = 4'd5;
  localparam logic [OP_W-1:0] OP_DATA_HI_RD = 4'd6;
  localparam logic [OP_W-1:0] OP_DIRECT_RD  = 4'd7;
  localparam logic [OP_W-1:0] OP_DIRECT_WR  = 4'd8;

  // Step select codes from the mode byte.
  localparam logic [1:0] STEP_SEL_ONE = 2'd0;
  localparam logic [1:0] STEP_SEL_32  = 2'd1;

  // Address steps.
  localparam logic [WORD_W-1:0] STEP_ONE = 16'd1;
  localparam logic [WORD_W-1:0] STEP_32  = 16'd32;
  localparam logic [WORD_W-1:0] STEP_128 = 16'd128;

  // Remap mode codes.
  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;
  localparam logic [1:0] REMAP_10   = 2'd3;

  // Rotate the low 8, 9 or 10 address bits left by three; REMAP_NONE leaves the address unchanged.
  function automatic logic [WORD_W-1:0] remap_address(input logic [WORD_W-1:0] a,
                                                      input logic [1:0] mode);
    logic [WORD_W-1:0] r;
    begin
      case (mode)
        REMAP_8:  r = {a[15:8],  a[4:0], a[7:5]};
        REMAP_9:  r = {a[15:9],  a[5:0], a[8:6]};
        REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
        default:  r = a;
      endcase
      return r;
    end
  endfunction

  // Address step chosen by the step select code.
  function automatic logic [WORD_W-1:0] step_size(input logic [1:0] sel);
    logic [WORD_W-1:0] s;
    begin
      case (sel)
        STEP_SEL_ONE: s = STEP_ONE;
        STEP_SEL_32:  s = STEP_32;
        default:      s = STEP_128;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/video_ram_port_with_remap.sv]
// ----------------------------------------------------------------------------
// video_ram_port_with_remap
// Video memory of 16-bit words behind byte-wide CPU registers, with address
// remapping, auto-increment and a direct word port for the renderer.
// ----------------------------------------------------------------------------
// After reset the block clears its memory, one word a cycle, over all MEM_WORDS
// words (32768 with the default depth); in_stall stays high throughout. After
// that it takes one command per cycle as long as results are taken, and each
// command gives exactly one result transfer, through the second stage and then
// the output register, since the single-port memory registers its read data.
// A pending result holds the input side only while the output register is
// full and stalled.
`default_nettype none

module video_ram_port_with_remap (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [vrp_pkg::OP_W-1:0]    opcode,
  input  wire logic [vrp_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic [vrp_pkg::WORD_W-1:0]  direct_address,
  input  wire logic [vrp_pkg::WORD_W-1:0]  direct_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [vrp_pkg::BYTE_W-1:0]       read_byte,
  output logic [vrp_pkg::WORD_W-1:0]       direct_read_word
);

  import vrp_pkg::*;

  // Video memory and its read data register.
  logic [WORD_W-1:0] video_words [MEM_WORDS];
  logic [WORD_W-1:0] rdata;

  // Clearing pass after reset.
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // CPU-side registers.
  logic [WORD_W-1:0] access_address;
  logic [WORD_W-1:0] write_latch;
  logic [WORD_W-1:0] read_buffer;
  logic [1:0]        step_select;
  logic [1:0]        remap_mode;
  logic              trigger_on_high;

  // Second stage: waits for the memory read data.
  logic              s2_valid;
  logic              s2_fetch;
  logic              s2_direct;
  logic [BYTE_W-1:0] s2_rb;
  logic              s2_move;

  // Decode and memory control.
  logic              accept;
  logic              store_now;
  logic              fetch_now;
  logic              dir_rd;
  logic              dir_wr;
  logic [WORD_W-1:0] buf_cur;
  logic [WORD_W-1:0] latch_next;
  logic [WORD_W-1:0] addr_stepped;
  logic [WORD_W-1:0] remap_full;
  logic [ADDR_W-1:0] remap_idx;
  logic [ADDR_W-1:0] direct_idx;
  logic [BYTE_W-1:0] rb_now;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  // The second stage moves on when the output register is free or drains.
  assign s2_move  = s2_valid && (!out_valid || !out_stall);
  assign in_stall = clr_active || (s2_valid && !s2_move);
  assign accept   = in_valid && !in_stall;

  // A fetch still in the second stage supplies the read buffer's new value.
  assign buf_cur = (s2_valid && s2_fetch) ? rdata : read_buffer;

  // Command decode and the addresses of the access.
  always_comb begin
    latch_next   = write_latch;
    rb_now       = '0;
    store_now    = 1'b0;
    fetch_now    = 1'b0;
    dir_rd       = 1'b0;
    dir_wr       = 1'b0;
    addr_stepped = access_address + step_size(step_select);
    remap_full   = remap_address(access_address, remap_mode);
    remap_idx    = remap_full[ADDR_W-1:0];
    direct_idx   = direct_address[ADDR_W-1:0];
    unique case (opcode)
      OP_DATA_LO_WR: begin
        latch_next = {write_latch[15:8], data_byte};
        store_now  = accept && !trigger_on_high;
      end
      OP_DATA_HI_WR: begin
        latch_next = {data_byte, write_latch[7:0]};
        store_now  = accept && trigger_on_high;
      end
      OP_DATA_LO_RD: begin
        rb_now    = buf_cur[7:0];
        fetch_now = accept && !trigger_on_high;
      end
      OP_DATA_HI_RD: begin
        rb_now    = buf_cur[15:8];
        fetch_now = accept && trigger_on_high;
      end
      OP_DIRECT_RD: dir_rd = accept;
      OP_DIRECT_WR: dir_wr = accept;
      default: begin
      end
    endcase
  end

  // Memory port selection: the clearing pass owns the write port.
  always_comb begin
    mem_we    = clr_active || store_now || dir_wr;
    mem_re    = fetch_now || dir_rd;
    mem_raddr = fetch_now ? remap_idx : direct_idx;
    if (clr_active) begin
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (store_now) begin
      mem_waddr = remap_idx;
      mem_wdata = latch_next;
    end else begin
      mem_waddr = direct_idx;
      mem_wdata = direct_word;
    end
  end

  // Video memory: one write or one read a cycle, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      video_words[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= video_words[mem_raddr];
    end
  end

  // Clearing pass over every word after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {ADDR_W{1'b1}}) begin
        clr_active <= 1'b0;
      end
    end
  end

  // CPU-side registers, updated on the accepted command; the read buffer also takes a fetch leaving the second stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_address  <= '0;
      write_latch     <= '0;
      read_buffer     <= '0;
      step_select     <= STEP_SEL_ONE;
      remap_mode      <= REMAP_NONE;
      trigger_on_high <= 1'b0;
    end else begin
      if (s2_move && s2_fetch) begin
        read_buffer <= rdata;
      end
      if (accept) begin
        case (opcode)
          OP_MODE_WR: begin
            step_select     <= data_byte[1:0];
            remap_mode      <= data_byte[3:2];
            trigger_on_high <= data_byte[7];
          end
          OP_ADDR_LO: access_address <= {access_address[15:8], data_byte};
          OP_ADDR_HI: access_address <= {data_byte, access_address[7:0]};
          OP_DATA_LO_WR, OP_DATA_HI_WR: write_latch <= latch_next;
          default: begin
          end
        endcase
      end
      if (store_now) begin
        read_buffer <= latch_next;
      end
      if (store_now || fetch_now) begin
        access_address <= addr_stepped;
      end
    end
  end

  // Second stage: holds the command's result until the read data is ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_fetch  <= fetch_now;
      s2_direct <= dir_rd;
      s2_rb     <= rb_now;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      read_byte        <= s2_rb;
      direct_read_word <= s2_direct ? rdata : '0;
    end
  end

  // A transfer accepted at the input always enters the second stage.
  a_accept_enters_s2: assert property (@(posedge clk) disable iff (rst)
    accept |=> s2_valid)
    else $error("accepted transfer did not reach the second stage");

  // A held second stage keeps its read data for the output.
  a_s2_hold_keeps_data: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_move) |=> (s2_valid && $stable(rdata)))
    else $error("read data changed while the second stage was held");

  // The single memory port never reads and writes in one cycle.
  a_single_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  // The clearing pass ends only after the last word.
  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    ($past(clr_active) && !clr_active) |-> ($past(clr_addr) == {ADDR_W{1'b1}}))
    else $error("clearing pass ended early");

endmodule

`default_nettype wire
